@@ rtl/core/itp_pkg.sv @@
// Shared types, character codes and helper functions for the infix-to-postfix converter.
package itp_pkg;

    localparam int STACK_DEPTH_DEF = 32;
    localparam int Q_DEPTH         = 4;

    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;

    localparam logic [7:0] CH_0 = 8'h30;
    localparam logic [7:0] CH_9 = 8'h39;
    localparam logic [7:0] CH_UA = 8'h41;
    localparam logic [7:0] CH_UZ = 8'h5A;
    localparam logic [7:0] CH_LA = 8'h61;
    localparam logic [7:0] CH_LZ = 8'h7A;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW = 2'd1;
    localparam logic [1:0] ERR_UNOPENED = 2'd2;

    localparam logic [2:0] CLS_ALNUM = 3'd0;
    localparam logic [2:0] CLS_OPEN  = 3'd1;
    localparam logic [2:0] CLS_CLOSE = 3'd2;
    localparam logic [2:0] CLS_OP    = 3'd3;
    localparam logic [2:0] CLS_END   = 3'd4;

    typedef struct packed {
        logic [2:0] cls;
        logic [7:0] sym;
        logic [1:0] rank;
    } t_item;

    function automatic logic [1:0] f_rank(input logic [7:0] c);
        logic [1:0] r;
        r = 2'd0;
        if (c == CH_CARET) begin
            r = 2'd3;
        end else if (c == CH_STAR || c == CH_SLASH) begin
            r = 2'd2;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
            r = 2'd1;
        end
        return r;
    endfunction

    function automatic logic f_is_alnum(input logic [7:0] c);
        return (c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UZ) ||
               (c >= CH_LA && c <= CH_LZ);
    endfunction

endpackage

@@ rtl/core/itp_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module itp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/itp_front.sv @@
// Front end: classifies each incoming character and works out its operator rank.
module itp_front (
    input  logic          i_end_of_expr,
    input  logic [7:0]    i_symbol,
    output itp_pkg::t_item o_item
);

    always_comb begin
        o_item.sym  = i_symbol;
        o_item.rank = itp_pkg::f_rank(i_symbol);
        if (i_end_of_expr) begin
            o_item.cls = itp_pkg::CLS_END;
        end else if (itp_pkg::f_is_alnum(i_symbol)) begin
            o_item.cls = itp_pkg::CLS_ALNUM;
        end else if (i_symbol == itp_pkg::CH_OPEN) begin
            o_item.cls = itp_pkg::CLS_OPEN;
        end else if (i_symbol == itp_pkg::CH_CLOSE) begin
            o_item.cls = itp_pkg::CLS_CLOSE;
        end else begin
            o_item.cls = itp_pkg::CLS_OP;
        end
    end

endmodule

@@ rtl/core/itp_queue.sv @@
// Short FIFO of classified items between the front end and the stack engine.
module itp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  itp_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output itp_pkg::t_item o_item
);

    localparam int PW = $clog2(itp_pkg::Q_DEPTH);
    localparam int CW = $clog2(itp_pkg::Q_DEPTH + 1);

    itp_pkg::t_item r_mem [itp_pkg::Q_DEPTH];
    logic [PW-1:0]  r_wptr;
    logic [PW-1:0]  r_rptr;
    logic [CW-1:0]  r_cnt;
    logic [CW-1:0]  n_cnt;

    assign o_full  = (r_cnt == CW'(itp_pkg::Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rptr];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PW'(itp_pkg::Q_DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PW'(itp_pkg::Q_DEPTH - 1)) ? '0 : r_rptr + PW'(1);
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

@@ rtl/core/itp_back.sv @@
// Stack engine: executes queued items on a stack, one step per cycle unless stalled.
module itp_back #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_valid,
    input  itp_pkg::t_item                 i_q_item,
    output logic                           o_q_pop,
    output logic                           o_we,
    output logic [$clog2(STACK_DEPTH)-1:0] o_waddr,
    output logic [7:0]                     o_wdata,
    output logic [$clog2(STACK_DEPTH)-1:0] o_raddr,
    input  logic [7:0]                     i_rdata,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [7:0]                     o_out_symbol,
    output logic                           o_has_symbol,
    output logic                           o_last,
    output logic [1:0]                     o_error
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [7:0]    r_top;
    logic [7:0]    n_top;
    logic [CW-1:0] below;

    logic       r_ovalid;
    logic [7:0] r_osym;
    logic       r_ohas;
    logic       r_olast;
    logic [1:0] r_oerr;

    logic       emit_ok;
    logic       emit;
    logic [7:0] e_sym;
    logic       e_has;
    logic       e_last;
    logic [1:0] e_err;
    logic       pop;
    logic       push;
    logic       full;
    logic       empty;
    logic       top_open;
    logic       one_left;
    logic [1:0] top_rank;
    logic       beats;

    assign emit_ok  = !r_ovalid || !i_stall;
    assign full     = (r_count == CW'(STACK_DEPTH));
    assign empty    = (r_count == '0);
    assign one_left = (r_count == CW'(1));
    assign top_open = (r_top == itp_pkg::CH_OPEN);
    assign top_rank = itp_pkg::f_rank(r_top);
    // The stacked operator leaves first if it binds tighter, or equally tight
    // unless the incoming operator is the right-associative caret.
    assign beats = !empty && !top_open &&
                   ((top_rank > i_q_item.rank) ||
                    (top_rank == i_q_item.rank && i_q_item.sym != itp_pkg::CH_CARET));

    always_comb begin
        o_q_pop = 1'b0;
        emit    = 1'b0;
        e_sym   = '0;
        e_has   = 1'b0;
        e_last  = 1'b0;
        e_err   = itp_pkg::ERR_NONE;
        pop     = 1'b0;
        push    = 1'b0;
        if (i_q_valid) begin
            unique case (i_q_item.cls)
                itp_pkg::CLS_END: begin
                    if (emit_ok) begin
                        emit = 1'b1;
                        if (empty) begin
                            e_last  = 1'b1;
                            o_q_pop = 1'b1;
                        end else begin
                            e_sym   = r_top;
                            e_has   = 1'b1;
                            e_last  = one_left;
                            pop     = 1'b1;
                            o_q_pop = one_left;
                        end
                    end
                end
                itp_pkg::CLS_ALNUM: begin
                    if (emit_ok) begin
                        emit    = 1'b1;
                        e_sym   = i_q_item.sym;
                        e_has   = 1'b1;
                        o_q_pop = 1'b1;
                    end
                end
                itp_pkg::CLS_OPEN: begin
                    if (full) begin
                        if (emit_ok) begin
                            emit    = 1'b1;
                            e_err   = itp_pkg::ERR_OVERFLOW;
                            o_q_pop = 1'b1;
                        end
                    end else begin
                        push    = 1'b1;
                        o_q_pop = 1'b1;
                    end
                end
                itp_pkg::CLS_CLOSE: begin
                    if (empty) begin
                        if (emit_ok) begin
                            emit    = 1'b1;
                            e_err   = itp_pkg::ERR_UNOPENED;
                            o_q_pop = 1'b1;
                        end
                    end else if (top_open) begin
                        pop     = 1'b1;
                        o_q_pop = 1'b1;
                    end else if (emit_ok) begin
                        emit  = 1'b1;
                        e_sym = r_top;
                        e_has = 1'b1;
                        pop   = 1'b1;
                    end
                end
                itp_pkg::CLS_OP: begin
                    if (beats) begin
                        if (emit_ok) begin
                            emit  = 1'b1;
                            e_sym = r_top;
                            e_has = 1'b1;
                            pop   = 1'b1;
                        end
                    end else if (full) begin
                        if (emit_ok) begin
                            emit    = 1'b1;
                            e_err   = itp_pkg::ERR_OVERFLOW;
                            o_q_pop = 1'b1;
                        end
                    end else begin
                        push    = 1'b1;
                        o_q_pop = 1'b1;
                    end
                end
                default: begin
                    o_q_pop = 1'b1;
                end
            endcase
        end
    end

    // The top of the stack lives in r_top; the memory read port always holds
    // the entry just below it, so a pop can refill r_top in the same cycle.
    always_comb begin
        n_count = r_count;
        n_top   = r_top;
        if (push) begin
            n_count = r_count + CW'(1);
            n_top   = i_q_item.sym;
        end else if (pop) begin
            n_count = r_count - CW'(1);
            n_top   = i_rdata;
        end
    end

    assign below   = n_count - CW'(2);
    assign o_raddr = below[AW-1:0];
    assign o_we    = push;
    assign o_waddr = r_count[AW-1:0];
    assign o_wdata = i_q_item.sym;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        if (emit) begin
            r_osym  <= e_sym;
            r_ohas  <= e_has;
            r_olast <= e_last;
            r_oerr  <= e_err;
        end
    end

    assign o_valid      = r_ovalid;
    assign o_out_symbol = r_osym;
    assign o_has_symbol = r_ohas;
    assign o_last       = r_olast;
    assign o_error      = r_oerr;

endmodule

@@ rtl/core/infix_to_postfix_converter_top.sv @@
// With the queue empty, an accepted character is first written into the queue; the stack
// engine then registers its first result into the output register.
// The stack engine takes one step per operand, push, bracket drop, error or end met with
// an empty stack, plus one step per operator popped off, and holds any step that emits
// while the output is stalled. A four-entry queue decouples input from it.
// Reset (synchronous, active low) empties the queue, the stack count and the output
// register; the stack memory itself is not cleared.
module infix_to_postfix_converter_top #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_symbol,
    input  logic       i_end_of_expr,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_symbol,
    output logic       o_has_symbol,
    output logic       o_last,
    output logic [1:0] o_error
);

    localparam int AW = $clog2(STACK_DEPTH);

    itp_pkg::t_item fr_item;
    itp_pkg::t_item q_item;
    logic           q_full;
    logic           q_valid;
    logic           q_pop;
    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic [7:0]     mem_wdata;
    logic [AW-1:0]  mem_raddr;
    logic [7:0]     mem_rdata;

    assign o_stall = q_full;

    itp_front u_front (
        .i_end_of_expr (i_end_of_expr),
        .i_symbol      (i_symbol),
        .o_item        (fr_item)
    );

    itp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid && !q_full),
        .i_item  (fr_item),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    itp_ram #(
        .WIDTH (8),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    itp_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_item     (q_item),
        .o_q_pop      (q_pop),
        .o_we         (mem_we),
        .o_waddr      (mem_waddr),
        .o_wdata      (mem_wdata),
        .o_raddr      (mem_raddr),
        .i_rdata      (mem_rdata),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_symbol (o_out_symbol),
        .o_has_symbol (o_has_symbol),
        .o_last       (o_last),
        .o_error      (o_error)
    );

endmodule
